// ===== hw/rtl/rsbd_pkg.sv =====
// rsbd_pkg: shared constants, register indexes and stage types of the
// region state bit deposit block. No dependencies.
package rsbd_pkg;

   localparam int SITES          = 63;
   localparam int SRC_BITS       = 64;
   localparam int CNT_BITS       = 6;
   localparam int GROUP          = 8;
   localparam int GROUPS         = 8;
   localparam int LOC_BITS       = 3;
   localparam int TOT_BITS       = 4;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 64;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SITE_COUNT     = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REGION_MEMBERS = 4'd1;

   localparam logic [CNT_BITS-1:0] SITE_COUNT_RESET = 6'd8;

   typedef struct packed {
      logic [SITES-1:0] region;
      logic [SITES-1:0] span;
   } masks_type;

   typedef logic [SITES-1:0][LOC_BITS-1:0]    local_count_type;
   typedef logic [GROUPS-2:0][TOT_BITS-1:0]   group_total_type;
   typedef logic [GROUPS-1:0][CNT_BITS-1:0]   group_offset_type;

endpackage

// ===== hw/rtl/rsbd_if.sv =====
// rsbd_if: valid/ready channel interfaces of the bit deposit block
// (request, response, register write). Depends on rsbd_pkg.
interface rsbd_req_if import rsbd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SRC_BITS-1:0] region_state;
   logic [SRC_BITS-1:0] rest_state;
   modport source (output valid, output region_state, output rest_state, input ready);
   modport sink   (input valid, input region_state, input rest_state, output ready);
endinterface

interface rsbd_rsp_if import rsbd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [SITES-1:0] full_state;
   modport source (output valid, output full_state, input ready);
   modport sink   (input valid, input full_state, output ready);
endinterface

interface rsbd_csr_if import rsbd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/rsbd_mask_stage.sv =====
// rsbd_mask_stage: first pipeline stage, builds region and span masks from
// the configuration and registers them with the item. Depends on rsbd_pkg.
module rsbd_mask_stage import rsbd_pkg::*; #(
   parameter int STATE_BITS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [STATE_BITS-1:0] region_state,
   input  logic [STATE_BITS-1:0] rest_state,
   input  logic [CNT_BITS-1:0]   site_count,
   input  logic [SITES-1:0]      region_members,
   output logic                  out_valid,
   input  logic                  out_ready,
   output masks_type             masks,
   output logic [STATE_BITS-1:0] region_src,
   output logic [STATE_BITS-1:0] rest_src
);

   logic                  valid_ff;
   masks_type             masks_ff, masks_in;
   logic [STATE_BITS-1:0] region_ff, rest_ff;
   logic [SITES-1:0]      reversed;
   logic [CNT_BITS-1:0]   shamt;

   // site x lands on bit n-1-x: reverse, then shift down by SITES-n
   always_comb begin
      for (int i = 0; i < SITES; i++) begin
         reversed[i] = region_members[SITES-1-i];
      end
      shamt          = CNT_BITS'(SITES) - site_count;
      masks_in.span  = ~({SITES{1'b1}} << site_count);
      masks_in.region = (reversed >> shamt) & masks_in.span;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         masks_ff  <= masks_in;
         region_ff <= region_state;
         rest_ff   <= rest_state;
      end
   end

   assign out_valid  = valid_ff;
   assign masks      = masks_ff;
   assign region_src = region_ff;
   assign rest_src   = rest_ff;

endmodule

// ===== hw/rtl/rsbd_count_stage.sv =====
// rsbd_count_stage: two pipeline stages of prefix counting over the region
// mask, per-group local counts then group offsets. Depends on rsbd_pkg.
module rsbd_count_stage import rsbd_pkg::*; #(
   parameter int STATE_BITS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  masks_type             masks_i,
   input  logic [STATE_BITS-1:0] region_i,
   input  logic [STATE_BITS-1:0] rest_i,
   output logic                  out_valid,
   input  logic                  out_ready,
   output masks_type             masks_o,
   output logic [STATE_BITS-1:0] region_o,
   output logic [STATE_BITS-1:0] rest_o,
   output local_count_type       loc_o,
   output group_offset_type      off_o
);

   // stage A: local counts within groups of eight
   logic                  a_valid_ff;
   logic                  a_ready;
   masks_type             a_masks_ff;
   logic [STATE_BITS-1:0] a_region_ff, a_rest_ff;
   local_count_type       a_loc_ff, a_loc_in;
   group_total_type       a_tot_ff, a_tot_in;

   // stage B: group offsets
   logic                  b_valid_ff;
   masks_type             b_masks_ff;
   logic [STATE_BITS-1:0] b_region_ff, b_rest_ff;
   local_count_type       b_loc_ff;
   group_offset_type      b_off_ff, b_off_in;

   always_comb begin
      logic [TOT_BITS-1:0] cnt;
      a_tot_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         cnt = '0;
         for (int j = 0; j < GROUP; j++) begin
            if (g * GROUP + j < SITES) begin
               a_loc_in[g*GROUP+j] = cnt[LOC_BITS-1:0];
               cnt = cnt + TOT_BITS'(masks_i.region[g*GROUP+j]);
            end
         end
         if (g < GROUPS - 1) begin
            a_tot_in[g] = cnt;
         end
      end
   end

   always_comb begin
      b_off_in[0] = '0;
      for (int g = 1; g < GROUPS; g++) begin
         b_off_in[g] = b_off_in[g-1] + CNT_BITS'(a_tot_ff[g-1]);
      end
   end

   assign in_ready = !a_valid_ff || a_ready;
   assign a_ready  = !b_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            a_valid_ff <= in_valid;
         end
         if (a_ready) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         a_masks_ff  <= masks_i;
         a_region_ff <= region_i;
         a_rest_ff   <= rest_i;
         a_loc_ff    <= a_loc_in;
         a_tot_ff    <= a_tot_in;
      end
      if (a_ready && a_valid_ff) begin
         b_masks_ff  <= a_masks_ff;
         b_region_ff <= a_region_ff;
         b_rest_ff   <= a_rest_ff;
         b_loc_ff    <= a_loc_ff;
         b_off_ff    <= b_off_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign masks_o   = b_masks_ff;
   assign region_o  = b_region_ff;
   assign rest_o    = b_rest_ff;
   assign loc_o     = b_loc_ff;
   assign off_o     = b_off_ff;

endmodule

// ===== hw/rtl/rsbd_scatter_stage.sv =====
// rsbd_scatter_stage: last pipeline stage, selects each output bit from the
// region or rest source by its prefix count. Depends on rsbd_pkg.
module rsbd_scatter_stage import rsbd_pkg::*; #(
   parameter int STATE_BITS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  masks_type             masks,
   input  logic [STATE_BITS-1:0] region_src,
   input  logic [STATE_BITS-1:0] rest_src,
   input  local_count_type       loc,
   input  group_offset_type      off,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [SITES-1:0]      full_state
);

   logic                valid_ff;
   logic [SITES-1:0]    full_ff, full_in;
   logic [SRC_BITS-1:0] region_wide, rest_wide;

   // bits above STATE_BITS read as zero
   assign region_wide = SRC_BITS'(region_src);
   assign rest_wide   = SRC_BITS'(rest_src);

   // rest mask is the span minus the region, so its count is p minus ridx
   always_comb begin
      logic [CNT_BITS-1:0] ridx;
      logic [CNT_BITS-1:0] cidx;
      for (int p = 0; p < SITES; p++) begin
         ridx = off[p / GROUP] + CNT_BITS'(loc[p]);
         cidx = CNT_BITS'(p) - ridx;
         if (masks.region[p]) begin
            full_in[p] = region_wide[ridx];
         end else if (masks.span[p]) begin
            full_in[p] = rest_wide[cidx];
         end else begin
            full_in[p] = 1'b0;
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         full_ff <= full_in;
      end
   end

   assign out_valid  = valid_ff;
   assign full_state = full_ff;

endmodule

// ===== hw/rtl/region_state_bit_deposit_top.sv =====
// region_state_bit_deposit_top: top level of the region state bit deposit
// block. Depends on rsbd_pkg, rsbd_if and the three stage modules.
//
// Usage:
//   req_chan carries one item: region_state and rest_state, two compressed
//   states. rsp_chan returns one item per request: full_state, both states
//   deposited into the region and complement masks of the site positions.
//   csr_chan writes site_count (index 0) and region_members (index 1); it
//   is always ready. Other indexes are ignored. Write only while idle.
// Pipeline: a request passes the mask build, local counts, group offsets
//   and scatter registers in turn before its response is valid.
// Throughput: one item per cycle while rsp_chan.ready is high.
// Reset: pipeline empties, site_count returns to 8, region_members to 0.
// Stall: when rsp_chan.ready is low the response holds; earlier stages
//   keep filling until the pipe is full, then req_chan.ready drops. No item
//   is lost or repeated.
module region_state_bit_deposit_top import rsbd_pkg::*; #(
   parameter int STATE_BITS = 64
) (
   input  logic       clock,
   input  logic       reset,
   rsbd_req_if.sink   req_chan,
   rsbd_rsp_if.source rsp_chan,
   rsbd_csr_if.sink   csr_chan
);

   logic [CNT_BITS-1:0] site_count_ff;
   logic [SITES-1:0]    members_ff;

   logic                  s1_valid, s1_ready;
   masks_type             s1_masks;
   logic [STATE_BITS-1:0] s1_region, s1_rest;

   logic                  s3_valid, s3_ready;
   masks_type             s3_masks;
   logic [STATE_BITS-1:0] s3_region, s3_rest;
   local_count_type       s3_loc;
   group_offset_type      s3_off;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         site_count_ff <= SITE_COUNT_RESET;
         members_ff    <= '0;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_SITE_COUNT:     site_count_ff <= csr_chan.data[CNT_BITS-1:0];
            CSR_REGION_MEMBERS: members_ff    <= csr_chan.data[SITES-1:0];
            default: ;
         endcase
      end
   end

   rsbd_mask_stage #(.STATE_BITS(STATE_BITS)) u_mask (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_chan.valid),
      .in_ready       (req_chan.ready),
      .region_state   (req_chan.region_state[STATE_BITS-1:0]),
      .rest_state     (req_chan.rest_state[STATE_BITS-1:0]),
      .site_count     (site_count_ff),
      .region_members (members_ff),
      .out_valid      (s1_valid),
      .out_ready      (s1_ready),
      .masks          (s1_masks),
      .region_src     (s1_region),
      .rest_src       (s1_rest)
   );

   rsbd_count_stage #(.STATE_BITS(STATE_BITS)) u_count (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .masks_i   (s1_masks),
      .region_i  (s1_region),
      .rest_i    (s1_rest),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .masks_o   (s3_masks),
      .region_o  (s3_region),
      .rest_o    (s3_rest),
      .loc_o     (s3_loc),
      .off_o     (s3_off)
   );

   rsbd_scatter_stage #(.STATE_BITS(STATE_BITS)) u_scatter (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s3_valid),
      .in_ready   (s3_ready),
      .masks      (s3_masks),
      .region_src (s3_region),
      .rest_src   (s3_rest),
      .loc        (s3_loc),
      .off        (s3_off),
      .out_valid  (rsp_chan.valid),
      .out_ready  (rsp_chan.ready),
      .full_state (rsp_chan.full_state)
   );

endmodule

// ===== hw/rtl/rsbd_checker.sv =====
// rsbd_checker: port-level assertions of the bit deposit block and the bind
// that attaches them to the top level. Depends on rsbd_pkg.
module rsbd_checker import rsbd_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [SITES-1:0]          full_state,
   input logic                      csr_valid,
   input logic                      csr_ready,
   input logic [CSR_INDEX_BITS-1:0] csr_index,
   input logic [CNT_BITS-1:0]       csr_count
);

   logic [CNT_BITS-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= SITE_COUNT_RESET;
      end else if (csr_valid && csr_ready && csr_index == CSR_SITE_COUNT) begin
         count_ff <= csr_count;
      end
   end

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_upper_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((full_state >> count_ff) == '0))
      else $error("full_state has bits at or above site_count");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(full_state))
      else $error("stalled response changed");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("item not delivered after four free cycles");

endmodule

bind region_state_bit_deposit_top rsbd_checker u_rsbd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .full_state (rsp_chan.full_state),
   .csr_valid  (csr_chan.valid),
   .csr_ready  (csr_chan.ready),
   .csr_index  (csr_chan.index),
   .csr_count  (csr_chan.data[5:0])
);

// ===== test/region_state_bit_deposit_top_tb.sv =====
// region_state_bit_deposit_top_tb: self-checking testbench for the region state bit
// deposit block. A scoreboard class predicts each full_state from its own copy of the
// registers; plain tasks drive items and register writes. Depends on rsbd_pkg, rsbd_if.
module region_state_bit_deposit_top_tb;
   import rsbd_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRST_UNUSED = CSR_REGION_MEMBERS + 1'b1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LAST_UNUSED  = '1;

   class deposit_scoreboard;
      logic [CNT_BITS-1:0] site_count;
      logic [SITES-1:0]    members;
      logic [SITES-1:0]    expected_states[$];
      int                  errors;

      function new();
         site_count = SITE_COUNT_RESET;
         members    = '0;
         errors     = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] index,
                                   logic [CSR_DATA_BITS-1:0] data);
         case (index)
            CSR_SITE_COUNT:     site_count = data[CNT_BITS-1:0];
            CSR_REGION_MEMBERS: members    = data[SITES-1:0];
            default: ;
         endcase
      endfunction

      function logic [SITES-1:0] scatter(logic [SRC_BITS-1:0] src, logic [SITES-1:0] mask);
         logic [SITES-1:0] dst;
         int               k;
         dst = '0;
         k   = 0;
         for (int p = 0; p < SITES; p++) begin
            if (mask[p]) begin
               dst[p] = src[k];
               k++;
            end
         end
         return dst;
      endfunction

      function void note_input(logic [SRC_BITS-1:0] region_state,
                               logic [SRC_BITS-1:0] rest_state);
         logic [SITES-1:0] region_mask;
         logic [SITES-1:0] span;
         int               n;
         n           = int'(site_count);
         region_mask = '0;
         // site x lands on position n-1-x; members at or above n drop out
         for (int x = 0; x < n; x++) begin
            if (members[x]) region_mask[n-1-x] = 1'b1;
         end
         span = {SITES{1'b1}} >> (SITES - n);
         expected_states.push_back(scatter(region_state, region_mask) |
                                   scatter(rest_state, span ^ region_mask));
      endfunction

      function void check_result(logic [SITES-1:0] got);
         logic [SITES-1:0] want;
         if (expected_states.size() == 0) begin
            errors++;
            if (errors <= 100)
               $display("%0t: unexpected full_state: expected none, actual %h", $time, got);
            return;
         end
         want = expected_states.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 100)
               $display("%0t: full_state mismatch: expected %h, actual %h", $time, want, got);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   tx_fast = 1'b0;
   bit   rx_fast = 1'b0;
   int   rsp_hold = 0;

   deposit_scoreboard board = new();

   rsbd_req_if req_chan ();
   rsbd_rsp_if rsp_chan ();
   rsbd_csr_if csr_chan ();

   region_state_bit_deposit_top #(
      .STATE_BITS (64)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #5 clock = ~clock;

   // receiver: after each item, ready drops for a random stall unless rx_fast
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_chan.ready = 1'b0;
         rsp_hold--;
      end else begin
         rsp_chan.ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         board.check_result(rsp_chan.full_state);
         rsp_hold = rx_fast ? 0 : $urandom_range(0, 7);
      end
   end

   function automatic logic [SRC_BITS-1:0] random_state();
      logic [SRC_BITS-1:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: v = '1;
         1: v = '0;
         2: v = v & {$urandom, $urandom};
         3: v = v | {$urandom, $urandom};
         default: ;
      endcase
      return v;
   endfunction

   task automatic send_item(input logic [SRC_BITS-1:0] region_state,
                            input logic [SRC_BITS-1:0] rest_state);
      int gap;
      gap = tx_fast ? 0 : $urandom_range(0, 7);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid        = 1'b1;
      req_chan.region_state = region_state;
      req_chan.rest_state   = rest_state;
      do @(posedge clock); while (!req_chan.ready);
      board.note_input(region_state, rest_state);
   endtask

   // hold off until every item has come back and the pipe has drained
   task automatic wait_idle();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (board.expected_states.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      wait_idle();
      @(negedge clock);
      csr_chan.valid = 1'b1;
      csr_chan.index = index;
      csr_chan.data  = data;
      do @(posedge clock); while (!csr_chan.ready);
      board.write_register(index, data);
      @(negedge clock);
      csr_chan.valid = 1'b0;
   endtask

   task automatic directed_items();
      tx_fast = 1'($urandom_range(0, 1));
      rx_fast = 1'($urandom_range(0, 1));
      send_item('1, '0);
      send_item('0, '1);
      send_item(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
      send_item(random_state(), random_state());
   endtask

   initial begin
      logic [CSR_DATA_BITS-1:0] count_data;
      logic [CSR_DATA_BITS-1:0] member_data;
      bit                       members_first;

      req_chan.valid        = 1'b0;
      req_chan.region_state = '0;
      req_chan.rest_state   = '0;
      csr_chan.valid        = 1'b0;
      csr_chan.index        = CSR_SITE_COUNT;
      csr_chan.data         = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset values: eight sites, empty subregion
      directed_items();
      write_csr(CSR_SITE_COUNT, '1);
      write_csr(CSR_REGION_MEMBERS, '1);
      directed_items();
      write_csr(CSR_REGION_MEMBERS, 64'h5555_5555_5555_5555);
      directed_items();
      // upper data bits dropped: no sites at all
      write_csr(CSR_SITE_COUNT, 64'hFFFF_FFFF_FFFF_FFC0);
      directed_items();
      write_csr(CSR_SITE_COUNT, 64'd1);
      directed_items();
      // members above the site count, then writes to unused indexes
      write_csr(CSR_SITE_COUNT, 64'd5);
      write_csr(CSR_REGION_MEMBERS, 64'hFFFF_FFFF_FFFF_FFE5);
      write_csr(CSR_FIRST_UNUSED, '1);
      write_csr(CSR_LAST_UNUSED, '0);
      directed_items();

      for (int phase = 0; phase < 20; phase++) begin
         count_data = {$urandom, $urandom};
         case ($urandom_range(0, 7))
            0: count_data[CNT_BITS-1:0] = '0;
            1: count_data[CNT_BITS-1:0] = 6'd1;
            2: count_data[CNT_BITS-1:0] = 6'd63;
            3: count_data[CNT_BITS-1:0] = 6'd62;
            default: count_data[CNT_BITS-1:0] = CNT_BITS'($urandom_range(1, 63));
         endcase
         member_data = {$urandom, $urandom};
         case ($urandom_range(0, 7))
            0: member_data = '1;
            1: member_data = '0;
            2: member_data = member_data & {$urandom, $urandom};
            3: member_data = member_data | {$urandom, $urandom};
            4: member_data = 64'd1 << $urandom_range(0, 63);
            default: ;
         endcase
         members_first = 1'($urandom_range(0, 1));
         if (members_first) write_csr(CSR_REGION_MEMBERS, member_data);
         write_csr(CSR_SITE_COUNT, count_data);
         if (!members_first) write_csr(CSR_REGION_MEMBERS, member_data);
         if ($urandom_range(0, 3) == 0)
            write_csr(CSR_INDEX_BITS'($urandom_range(CSR_FIRST_UNUSED, CSR_LAST_UNUSED)),
                      {$urandom, $urandom});
         tx_fast = ($urandom_range(0, 3) == 0);
         rx_fast = ($urandom_range(0, 3) == 0);
         repeat (100) send_item(random_state(), random_state());
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (board.errors == 0 && board.expected_states.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== region_state_bit_deposit_top.f =====
hw/rtl/rsbd_pkg.sv
hw/rtl/rsbd_if.sv
hw/rtl/rsbd_mask_stage.sv
hw/rtl/rsbd_count_stage.sv
hw/rtl/rsbd_scatter_stage.sv
hw/rtl/region_state_bit_deposit_top.sv
hw/rtl/rsbd_checker.sv
test/region_state_bit_deposit_top_tb.sv
